### rtl/lspb_pkg.sv
// shared types, command codes and register reset values for the status led blinker
package lspb_pkg;

	// command codes carried on cmd
	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_OVERRIDE = 2'd1,
		CMD_RELEASE  = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	// controller state codes
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_START    = 3'd1,
		ST_TRACKING = 3'd2,
		ST_ELEMENT  = 3'd3,
		ST_ERROR    = 3'd4,
		ST_FINISH   = 3'd5,
		ST_SPARE6   = 3'd6,
		ST_SPARE7   = 3'd7
	} ctrl_state_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PRESCALE  = 3'd0,
		REG_TIMEOUT   = 3'd1,
		REG_PAT_IDLE  = 3'd2,
		REG_PAT_START = 3'd3,
		REG_PAT_TRACK = 3'd4,
		REG_PAT_ELEM  = 3'd5,
		REG_PAT_ERROR = 3'd6,
		REG_PAT_FIN   = 3'd7
	} reg_idx_t;

	localparam int unsigned CfgDataW = 16;
	localparam int unsigned PatW     = 16;
	localparam int unsigned PhaseW   = 4;
	localparam int unsigned CountW   = 8;

	localparam logic [CountW-1:0] PrescaleRst  = 8'd10;
	localparam logic [CountW-1:0] TimeoutRst   = 8'd20;
	localparam logic [PatW-1:0]   PatIdleRst   = 16'h000F;
	localparam logic [PatW-1:0]   PatStartRst  = 16'h3333;
	localparam logic [PatW-1:0]   PatTrackRst  = 16'hFFFF;
	localparam logic [PatW-1:0]   PatElemRst   = 16'h8009;
	localparam logic [PatW-1:0]   PatErrorRst  = 16'hAAAA;
	localparam logic [PatW-1:0]   PatFinRst    = 16'hFFFF;
	localparam logic [CountW-1:0] FramesSatMax = 8'hFF;

	// settings seen by the frame logic
	typedef struct packed {
		logic [CountW-1:0] prescale;
		logic [CountW-1:0] timeout;
		logic [PatW-1:0]   pattern;
	} cfg_view_t;

endpackage

### rtl/lspb_cfg_regs.sv
// configuration registers and per-state blink pattern selection
module lspb_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [lspb_pkg::CfgDataW-1:0]   cfg_data,
	input  logic [2:0]                      sel_state,
	output lspb_pkg::cfg_view_t             view
);

	logic [lspb_pkg::CountW-1:0] prescale_q;
	logic [lspb_pkg::CountW-1:0] timeout_q;
	logic [lspb_pkg::PatW-1:0]   pat_idle_q;
	logic [lspb_pkg::PatW-1:0]   pat_start_q;
	logic [lspb_pkg::PatW-1:0]   pat_track_q;
	logic [lspb_pkg::PatW-1:0]   pat_elem_q;
	logic [lspb_pkg::PatW-1:0]   pat_error_q;
	logic [lspb_pkg::PatW-1:0]   pat_fin_q;
	logic [lspb_pkg::PatW-1:0]   pat_sel;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= lspb_pkg::PrescaleRst;
			timeout_q   <= lspb_pkg::TimeoutRst;
			pat_idle_q  <= lspb_pkg::PatIdleRst;
			pat_start_q <= lspb_pkg::PatStartRst;
			pat_track_q <= lspb_pkg::PatTrackRst;
			pat_elem_q  <= lspb_pkg::PatElemRst;
			pat_error_q <= lspb_pkg::PatErrorRst;
			pat_fin_q   <= lspb_pkg::PatFinRst;
		end else if (cfg_we) begin
			case (lspb_pkg::reg_idx_t'(cfg_index))
				lspb_pkg::REG_PRESCALE:  prescale_q  <= cfg_data[lspb_pkg::CountW-1:0];
				lspb_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[lspb_pkg::CountW-1:0];
				lspb_pkg::REG_PAT_IDLE:  pat_idle_q  <= cfg_data;
				lspb_pkg::REG_PAT_START: pat_start_q <= cfg_data;
				lspb_pkg::REG_PAT_TRACK: pat_track_q <= cfg_data;
				lspb_pkg::REG_PAT_ELEM:  pat_elem_q  <= cfg_data;
				lspb_pkg::REG_PAT_ERROR: pat_error_q <= cfg_data;
				lspb_pkg::REG_PAT_FIN:   pat_fin_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pattern for the current controller state, spare codes fall back to idle
	always_comb begin
		case (lspb_pkg::ctrl_state_t'(sel_state))
			lspb_pkg::ST_START:    pat_sel = pat_start_q;
			lspb_pkg::ST_TRACKING: pat_sel = pat_track_q;
			lspb_pkg::ST_ELEMENT:  pat_sel = pat_elem_q;
			lspb_pkg::ST_ERROR:    pat_sel = pat_error_q;
			lspb_pkg::ST_FINISH:   pat_sel = pat_fin_q;
			default:               pat_sel = pat_idle_q;
		endcase
	end

	assign view.prescale = prescale_q;
	assign view.timeout  = timeout_q;
	assign view.pattern  = pat_sel;

endmodule

### rtl/led_status_pattern_blinker.sv
// top level of the status led blink pattern generator
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// a tick, an override set with its forced level, or an override release.
// Output channel (out_valid / out_stall) carries the new led level.
// Ticks are counted up to view.prescale; each completed frame advances
// the 4-bit phase and produces one transfer with the pattern bit of the
// current controller state (the held level under override, low in the
// finish state past the timeout). An override set produces one transfer
// at once; a release, an unused code or a tick inside a frame produce
// none. A command is registered at the input on its transfer and its
// result enters the output register once that is free or being taken.
// Throughput is one command per cycle when out_stall is low, set by the
// single input register feeding the frame logic. When the receiver stalls
// with a result waiting, an empty input register still takes one more
// command and then in_stall rises until the output register is drained.
// Reset clears counters, phase, override and both pipeline stages, and
// loads the register defaults. Configuration is written on cfg_we.
module led_status_pattern_blinker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [lspb_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [2:0]                    controller_state,
	input  logic                          override_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          led_on
);

	logic                          valid_s1;
	logic [1:0]                    cmd_s1;
	logic [2:0]                    state_s1;
	logic                          level_s1;

	logic [lspb_pkg::CountW-1:0]   tick_count_q;
	logic [lspb_pkg::PhaseW-1:0]   frame_phase_q;
	logic [2:0]                    last_state_q;
	logic [lspb_pkg::CountW-1:0]   frames_q;
	logic                          override_on_q;
	logic                          override_held_q;
	logic                          out_valid_q;
	logic                          led_q;

	lspb_pkg::cfg_view_t           view;

	logic                          advance;
	logic                          proc;
	logic                          is_tick;
	logic                          is_set;
	logic                          is_release;
	logic [lspb_pkg::CountW-1:0]   tick_inc;
	logic                          frame_done;
	logic [lspb_pkg::PhaseW-1:0]   phase_next;
	logic                          state_changed;
	logic [lspb_pkg::CountW-1:0]   frames_next;
	logic                          emit;
	logic                          led_next;

	lspb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sel_state (state_s1),
		.view      (view)
	);

	// handshake: stage 1 moves on when the output slot is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1   <= cmd;
			state_s1 <= controller_state;
			level_s1 <= override_level;
		end
	end

	// command decode and frame arithmetic
	always_comb begin
		is_tick       = lspb_pkg::cmd_t'(cmd_s1) == lspb_pkg::CMD_TICK;
		is_set        = lspb_pkg::cmd_t'(cmd_s1) == lspb_pkg::CMD_OVERRIDE;
		is_release    = lspb_pkg::cmd_t'(cmd_s1) == lspb_pkg::CMD_RELEASE;
		tick_inc      = tick_count_q + 8'd1;
		frame_done    = is_tick && (tick_inc >= view.prescale);
		phase_next    = frame_phase_q + 4'd1;
		state_changed = state_s1 != last_state_q;
		if (state_changed) begin
			frames_next = '0;
		end else if (frames_q != lspb_pkg::FramesSatMax) begin
			frames_next = frames_q + 8'd1;
		end else begin
			frames_next = frames_q;
		end
		emit = is_set || frame_done;
		if (is_set) begin
			led_next = level_s1;
		end else if (override_on_q) begin
			led_next = override_held_q;
		end else if (lspb_pkg::ctrl_state_t'(state_s1) == lspb_pkg::ST_FINISH
				&& frames_next > view.timeout) begin
			led_next = 1'b0;
		end else begin
			led_next = view.pattern[phase_next];
		end
	end

	// blinker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			frame_phase_q   <= '0;
			last_state_q    <= lspb_pkg::ST_IDLE;
			frames_q        <= '0;
			override_on_q   <= 1'b0;
			override_held_q <= 1'b0;
		end else if (proc) begin
			if (is_set) begin
				override_on_q   <= 1'b1;
				override_held_q <= level_s1;
			end else if (is_release) begin
				override_on_q <= 1'b0;
			end else if (is_tick) begin
				if (frame_done) begin
					tick_count_q  <= '0;
					frame_phase_q <= phase_next;
					last_state_q  <= state_s1;
					frames_q      <= frames_next;
				end else begin
					tick_count_q <= tick_inc;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			led_q <= led_next;
		end
	end

	assign out_valid = out_valid_q;
	assign led_on    = led_q;

	// a completed frame restarts the tick count
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && frame_done) |=> (tick_count_q == '0))
		else $error("tick count not cleared after frame");

	// an override set is reported at once with its level
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && is_set) |=> (out_valid_q && led_q == $past(level_s1)
			&& override_on_q))
		else $error("override set transfer wrong");

	// commands without a result leave the output slot empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !emit) |=> !out_valid_q)
		else $error("spurious output transfer");

	// frame count saturates instead of wrapping
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && frame_done && !state_changed && frames_q == lspb_pkg::FramesSatMax)
			|=> (frames_q == lspb_pkg::FramesSatMax))
		else $error("frame count wrapped");

	// input stall only while a command waits behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without cause");

endmodule
